// ===== sv/mbrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrb_pkg: shared types, constants and helpers
// Frame layout, function codes and the per-byte CRC-16 update used by the
// request builder pipeline.
// ----------------------------------------------------------------------------
package mbrb_pkg;

    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] POLY_RESET = 16'hA001;
    localparam logic [7:0]  CODE_READ  = 8'h04;
    localparam logic [7:0]  CODE_WRITE = 8'h06;

    // Frame is eight bytes; the CRC covers the first six
    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned CRC_SPAN  = 6;

    typedef logic [2:0] byte_idx_t;

    localparam byte_idx_t IDX_CRC_LO = byte_idx_t'(CRC_SPAN);
    localparam byte_idx_t IDX_LAST   = byte_idx_t'(FRAME_LEN - 1);

    // Header bytes of one request frame
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  code;
        logic [15:0] register_address;
        logic [15:0] register_value;
    } frame_t;

    // What travels down the CRC pipeline
    typedef struct packed {
        frame_t      frame;
        logic [15:0] crc;
    } stage_t;

    // Header byte in transmission order
    function automatic logic [7:0] header_byte(input frame_t f, input byte_idx_t idx);
        logic [7:0] b;
        begin
            unique case (idx)
                3'd0:    b = f.slave_address;
                3'd1:    b = f.code;
                3'd2:    b = f.register_address[15:8];
                3'd3:    b = f.register_address[7:0];
                3'd4:    b = f.register_value[15:8];
                3'd5:    b = f.register_value[7:0];
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // Reflected CRC-16: fold in one byte, eight shift steps
    function automatic logic [15:0] crc_update(input logic [15:0] acc_in,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] acc;
        logic        lsb;
        begin
            acc = acc_in ^ {8'h00, data};
            for (int b = 0; b < 8; b++)
            begin
                lsb = acc[0];
                acc = {1'b0, acc[15:1]};
                if (lsb)
                begin
                    acc = acc ^ poly;
                end
            end
            return acc;
        end
    endfunction

endpackage

// ===== sv/mbrb_if.sv =====
// ----------------------------------------------------------------------------
// mbrb channel interfaces
// Request, frame byte and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface mbrb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [15:0] register_value;

    modport source (output valid, output req_type, output slave_address,
                    output register_address, output register_value, input ready);
    modport sink   (input valid, input req_type, input slave_address,
                    input register_address, input register_value, output ready);
endinterface

interface mbrb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface mbrb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mbrb_crc_stage.sv =====
// ----------------------------------------------------------------------------
// mbrb_crc_stage: one CRC pipeline stage
// Folds one header byte into the running CRC and registers the result.
// Stalls hold the stage; a bubble is filled whenever the stage is empty.
// ----------------------------------------------------------------------------
module mbrb_crc_stage #(
    parameter int unsigned BYTE_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     poly,
    input  logic            in_valid,
    output logic            in_ready,
    input  mbrb_pkg::stage_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mbrb_pkg::stage_t out_data
);
    import mbrb_pkg::*;

    localparam byte_idx_t SEL = byte_idx_t'(BYTE_IDX);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    // CRC step for this byte
    always_comb
    begin
        data_next       = in_data;
        data_next.crc   = crc_update(in_data.crc, header_byte(in_data.frame, SEL), poly);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid bit, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== sv/mbrb_serializer.sv =====
// ----------------------------------------------------------------------------
// mbrb_serializer: frame to byte stream
// Holds one finished frame and sends its eight bytes, CRC low then high
// last. Takes the next frame as the last byte leaves.
// ----------------------------------------------------------------------------
module mbrb_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mbrb_pkg::stage_t in_data,
    output logic             byte_valid,
    input  logic             byte_ready,
    output logic [7:0]       frame_byte,
    output logic             last_byte
);
    import mbrb_pkg::*;

    logic      busy_reg;
    byte_idx_t cnt_reg;
    stage_t    hold_reg;
    logic      is_last;

    assign is_last    = (cnt_reg == IDX_LAST);
    assign byte_valid = busy_reg;
    assign last_byte  = is_last;
    assign in_ready   = !busy_reg || (byte_ready && is_last);

    // Byte select
    always_comb
    begin
        if (cnt_reg == IDX_LAST)
        begin
            frame_byte = hold_reg.crc[15:8];
        end
        else if (cnt_reg == IDX_CRC_LO)
        begin
            frame_byte = hold_reg.crc[7:0];
        end
        else
        begin
            frame_byte = header_byte(hold_reg.frame, cnt_reg);
        end
    end

    // Busy flag and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (in_ready && in_valid)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg && byte_ready)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    // Frame hold register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_reg <= in_data;
        end
    end

endmodule

// ===== sv/modbus_rtu_request_builder.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_request_builder: Modbus RTU request frame generator
// Builds an eight-byte read (0x04) or write single register (0x06) frame
// with CRC-16 for each request.
// ----------------------------------------------------------------------------
// Usage:
//   req : request in (req_type, slave_address, register_address,
//         register_value), accepted on valid && ready.
//   rsp : frame bytes out in transmission order, last_byte on the CRC
//         high byte (eighth byte).
//   cfg : 16-bit write of the reflected CRC polynomial, always ready.
//         Write only while no frame is in flight.
// Path: an accepted request passes the six CRC stages, one byte each, then
//   the serializer, which presents the first byte of the frame.
// Throughput: one byte per cycle while rsp.ready is high; the serializer sets the
//   request rate by sending each frame's eight bytes before the next. The CRC
//   stages take a request every cycle unless stalled and buffer up to six meanwhile.
// Reset: all stages empty, polynomial back to 0xA001.
// Stall: when rsp.ready is low the current byte holds; stages fill up and
//   req.ready drops once all of them are occupied.
// ----------------------------------------------------------------------------
module modbus_rtu_request_builder (
    input logic         clk,
    input logic         rst_n,
    mbrb_req_if.sink    req,
    mbrb_byte_if.source rsp,
    mbrb_cfg_if.sink    cfg
);
    import mbrb_pkg::*;

    logic [15:0] poly_reg;
    logic        st_valid [CRC_SPAN+1];
    logic        st_ready [CRC_SPAN+1];
    stage_t      st_data  [CRC_SPAN+1];

    // Polynomial register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
        end
        else if (cfg.valid)
        begin
            poly_reg <= cfg.data;
        end
    end

    // Pipeline entry: header and CRC seed
    assign st_valid[0]                      = req.valid;
    assign req.ready                        = st_ready[0];
    assign st_data[0].frame.slave_address    = req.slave_address;
    assign st_data[0].frame.code             = req.req_type ? CODE_WRITE : CODE_READ;
    assign st_data[0].frame.register_address = req.register_address;
    assign st_data[0].frame.register_value   = req.register_value;
    assign st_data[0].crc                    = CRC_SEED;

    // One CRC stage per header byte
    for (genvar i = 0; i < CRC_SPAN; i++)
    begin : g_crc
        mbrb_crc_stage #(
            .BYTE_IDX (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .poly      (poly_reg),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_data   (st_data[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_data  (st_data[i+1])
        );
    end

    // Byte output
    mbrb_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (st_valid[CRC_SPAN]),
        .in_ready   (st_ready[CRC_SPAN]),
        .in_data    (st_data[CRC_SPAN]),
        .byte_valid (rsp.valid),
        .byte_ready (rsp.ready),
        .frame_byte (rsp.frame_byte),
        .last_byte  (rsp.last_byte)
    );

endmodule

// ===== sv/mbrb_checker.sv =====
// ----------------------------------------------------------------------------
// mbrb_checker: port-level checks for the request builder
// Tracks byte position on the output and checks framing and stall behavior.
// ----------------------------------------------------------------------------
module mbrb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] frame_byte,
    input logic       last_byte
);
    import mbrb_pkg::*;

    byte_idx_t pos_reg;

    // Output byte position within the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            pos_reg <= pos_reg + 3'd1;
        end
    end

    // Stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("stalled frame byte changed");

    // Last marker exactly on the eighth byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (last_byte == (pos_reg == IDX_LAST)))
        else $error("last_byte out of place");

    // Second byte is a function code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (pos_reg == 3'd1) |-> (frame_byte == CODE_READ) || (frame_byte == CODE_WRITE))
        else $error("bad function code");

endmodule

bind modbus_rtu_request_builder mbrb_checker u_mbrb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .frame_byte (rsp.frame_byte),
    .last_byte  (rsp.last_byte)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: Modbus RTU request builder check
// Sends read and write requests, rebuilds every eight-byte frame with its own
// CRC-16, and checks each frame byte and last flag against the DUT. The run
// covers several CRC polynomials, random gaps on both sides, a long output
// stall and a pause that lets the pipeline drain.
// ----------------------------------------------------------------------------
module testbench;

    import mbrb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 200;

    // Request as the testbench sees it
    typedef struct packed {
        logic        req_type;
        logic [7:0]  slave_address;
        logic [15:0] register_address;
        logic [15:0] register_value;
    } request_t;

    // Request waiting to be sent, with its lead-in gap
    typedef struct {
        request_t    fields;
        int unsigned gap;
        bit          drain;
    } pending_req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_byte_t;

    logic clk;
    logic rst_n;

    mbrb_req_if  req_ch ();
    mbrb_byte_if rsp_ch ();
    mbrb_cfg_if  cfg_ch ();

    modbus_rtu_request_builder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    pending_req_t pending_reqs[$];
    frame_byte_t  frame_bytes_due[$];

    logic [15:0]  crc_poly;
    int unsigned  errors;
    int unsigned  requests_sent;
    int unsigned  bytes_checked;
    int unsigned  polys_used;
    int unsigned  cycle_count;

    // Driver state
    pending_req_t cur_req;
    bit           have_item;
    int unsigned  gap_left;
    bit           show;

    // Monitor state
    int unsigned  rsp_idle_max;
    int unsigned  idle_left;
    int unsigned  hold_left;
    bit           stall_arm;
    bit           stall_taken;
    bit           rdy;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Build the expected frame for one request and queue its bytes
    function automatic void queue_frame(input request_t r, input logic [15:0] poly);
        logic [7:0]  bytes [8];
        logic [15:0] crc;
        frame_byte_t fb;
        bytes[0] = r.slave_address;
        bytes[1] = r.req_type ? CODE_WRITE : CODE_READ;
        bytes[2] = r.register_address[15:8];
        bytes[3] = r.register_address[7:0];
        bytes[4] = r.register_value[15:8];
        bytes[5] = r.register_value[7:0];
        crc = CRC_SEED;
        for (int k = 0; k < 6; k++)
        begin
            crc = crc ^ {8'h00, bytes[k]};
            for (int b = 0; b < 8; b++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
            end
        end
        bytes[6] = crc[7:0];
        bytes[7] = crc[15:8];
        for (int k = 0; k < 8; k++)
        begin
            fb.frame_byte = bytes[k];
            fb.last_byte  = (k == 7);
            frame_bytes_due.push_back(fb);
        end
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            have_item = 1'b0;
            gap_left  = 0;
        end
        else
        begin
            // request taken at this edge
            if (req_ch.valid && req_ch.ready)
            begin
                queue_frame(cur_req.fields, crc_poly);
                requests_sent++;
                have_item = 1'b0;
            end
            if (!have_item && pending_reqs.size() > 0)
            begin
                cur_req   = pending_reqs.pop_front();
                have_item = 1'b1;
                gap_left  = cur_req.gap;
            end
            show = 1'b0;
            if (have_item)
            begin
                if (req_ch.valid && !req_ch.ready)
                    show = 1'b1;
                else if (gap_left > 0)
                    gap_left--;
                else if (cur_req.drain && frame_bytes_due.size() != 0)
                    show = 1'b0;
                else
                    show = 1'b1;
            end
            req_ch.valid <= show;
            if (show)
            begin
                req_ch.req_type         <= cur_req.fields.req_type;
                req_ch.slave_address    <= cur_req.fields.slave_address;
                req_ch.register_address <= cur_req.fields.register_address;
                req_ch.register_value   <= cur_req.fields.register_value;
            end
        end
    end

    // Frame byte monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            idle_left   = 0;
            hold_left   = 0;
            stall_taken = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("frame_byte: no byte expected, got %h (last_byte %b)",
                           rsp_ch.frame_byte, rsp_ch.last_byte);
                    errors++;
                end
                else
                begin
                    frame_byte_t fb;
                    fb = frame_bytes_due.pop_front();
                    if (rsp_ch.frame_byte !== fb.frame_byte)
                    begin
                        $error("frame_byte: expected %h, got %h",
                               fb.frame_byte, rsp_ch.frame_byte);
                        errors++;
                    end
                    if (rsp_ch.last_byte !== fb.last_byte)
                    begin
                        $error("last_byte: expected %b, got %b",
                               fb.last_byte, rsp_ch.last_byte);
                        errors++;
                    end
                end
                bytes_checked++;
                idle_left = $urandom_range(0, rsp_idle_max);
            end
            // one long hold-off, armed by the stimulus
            if (stall_arm && !stall_taken)
            begin
                stall_taken = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            rsp_ch.ready <= rdy;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[modbus_rtu_request_builder] ERROR");
            $finish;
        end
    end

    task automatic add_request(input logic kind, input logic [7:0] slave,
                               input logic [15:0] addr, input logic [15:0] value,
                               input int unsigned gap, input bit drain);
        pending_req_t p;
        p.fields.req_type         = kind;
        p.fields.slave_address    = slave;
        p.fields.register_address = addr;
        p.fields.register_value   = value;
        p.gap   = gap;
        p.drain = drain;
        pending_reqs.push_back(p);
    endtask

    // 16-bit value with the extremes showing up often
    function automatic logic [15:0] pick16();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h8000;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    task automatic run_random(input int unsigned n, input int unsigned gap_max);
        for (int i = 0; i < n; i++)
        begin
            add_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        pick16(), pick16(), $urandom_range(0, gap_max),
                        $urandom_range(0, 39) == 0);
        end
    endtask

    // Block until every request is sent and every byte has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || have_item || frame_bytes_due.size() != 0);
    endtask

    task automatic write_poly(input logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        crc_poly = v;
        cfg_ch.valid <= 1'b0;
        polys_used++;
    endtask

    // Stimulus
    initial
    begin
        req_ch.valid            = 1'b0;
        req_ch.req_type         = 1'b0;
        req_ch.slave_address    = 8'h00;
        req_ch.register_address = 16'h0000;
        req_ch.register_value   = 16'h0000;
        rsp_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.data             = 16'h0000;
        crc_poly      = POLY_RESET;
        errors        = 0;
        requests_sent = 0;
        bytes_checked = 0;
        polys_used    = 1;
        cycle_count   = 0;
        rsp_idle_max  = 0;
        stall_arm     = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset polynomial, field extremes, both codes
        add_request(1'b0, 8'h01, 16'h0000, 16'h0001, 0, 0);
        add_request(1'b1, 8'h01, 16'h0001, 16'h0003, 0, 0);
        add_request(1'b0, 8'h00, 16'h0000, 16'h0000, 0, 0);
        add_request(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0);
        add_request(1'b0, 8'hFF, 16'h0000, 16'hFFFF, 0, 0);
        add_request(1'b1, 8'h00, 16'hFFFF, 16'h0000, 0, 0);
        // negative values: -32768 and -2
        add_request(1'b1, 8'h11, 16'h8000, 16'h8000, 0, 0);
        add_request(1'b1, 8'h7F, 16'h1234, 16'hFFFE, 0, 0);
        // sender waits for the pipeline to empty before this one
        add_request(1'b0, 8'h80, 16'h00FF, 16'hFF00, 0, 1);
        add_request(1'b1, 8'hAA, 16'h5555, 16'hAAAA, 3, 0);
        add_request(1'b0, 8'h55, 16'hAAAA, 16'h5555, 7, 0);
        add_request(1'b1, 8'hF7, 16'h0100, 16'h00FF, 15, 0);
        add_request(1'b0, 8'h01, 16'h7FFF, 16'h007D, 1, 0);
        add_request(1'b1, 8'h02, 16'hFF00, 16'h0001, 0, 0);
        wait_idle();

        // polynomial zero, heavy receiver idling
        write_poly(16'h0000);
        rsp_idle_max = 15;
        run_random(35, 15);
        wait_idle();

        // polynomial all ones, no random sender gaps
        write_poly(16'hFFFF);
        rsp_idle_max = 3;
        run_random(35, 0);
        wait_idle();

        // reflected CCITT polynomial, no random gaps on either side
        write_poly(16'h8408);
        rsp_idle_max = 0;
        run_random(35, 0);
        wait_idle();

        // long receiver hold-off while requests keep coming
        write_poly(16'($urandom_range(0, 65535)));
        rsp_idle_max = 2;
        stall_arm = 1'b1;
        run_random(25, 0);
        add_request(1'b1, 8'h3C, 16'hC3C3, 16'h8001, 0, 1);
        run_random(10, 4);
        wait_idle();

        // back to the reset value, random gaps everywhere
        write_poly(POLY_RESET);
        rsp_idle_max = 15;
        run_random(50, 15);
        wait_idle();

        write_poly(16'($urandom_range(0, 65535)));
        rsp_idle_max = 6;
        run_random(40, 8);
        wait_idle();

        repeat (20) @(posedge clk);
        $display("Covered %0d requests and %0d frame bytes under %0d CRC polynomials,",
                 requests_sent, bytes_checked, polys_used);
        $display("with random gaps, a %0d-cycle output stall and a drain pause.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("[modbus_rtu_request_builder] OK");
        else
            $display("[modbus_rtu_request_builder] ERROR");
        $finish;
    end

endmodule
